// ===== hdl/ntc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared types and constants of the numeric type converter.
// ----------------------------------------------------------------------------
package ntc_pkg;

   localparam int LongBits = 64;

   typedef enum logic [2:0] {
      TYPE_INT8    = 3'd0,
      TYPE_INT16   = 3'd1,
      TYPE_INT32   = 3'd2,
      TYPE_LONG    = 3'd3,
      TYPE_FLOAT32 = 3'd4,
      TYPE_FLOAT64 = 3'd5,
      TYPE_RSVD6   = 3'd6,
      TYPE_RSVD7   = 3'd7
   } num_type_type;

   typedef enum logic [1:0] {
      CSR_SOURCE_TYPE  = 2'd0,
      CSR_TARGET_TYPE  = 2'd1,
      CSR_ROUND_ENABLE = 2'd2,
      CSR_NONE         = 2'd3
   } csr_index_type;

   typedef struct packed {
      num_type_type source_type;
      num_type_type target_type;
      logic         round_enable;
   } cfg_type;

endpackage

// ===== hdl/ntc_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_decode
// Turns a source word of any configured type into float64 bits.
// ----------------------------------------------------------------------------
module ntc_decode (
   input  ntc_pkg::num_type_type source_type,
   input  logic [63:0]           raw,
   output logic [63:0]           dbl
);

   logic [63:0] ival;
   logic        neg;
   logic [63:0] mag;
   logic [6:0]  lz;
   logic        found;
   logic [63:0] norm;
   logic [10:0] exp_int;
   logic        rnd_up;
   logic [53:0] mant_r;
   logic [63:0] int_dbl;
   logic [7:0]  f_exp;
   logic [22:0] f_man;
   logic [4:0]  f_lz;
   logic        f_found;
   logic [22:0] f_norm;
   logic [63:0] flt_dbl;

   always_comb begin
      unique case (source_type)
         ntc_pkg::TYPE_INT8:  ival = {{56{raw[7]}}, raw[7:0]};
         ntc_pkg::TYPE_INT16: ival = {{48{raw[15]}}, raw[15:0]};
         ntc_pkg::TYPE_INT32: ival = {{32{raw[31]}}, raw[31:0]};
         default:             ival = raw[ntc_pkg::LongBits-1] ?
                                 (raw | ~({64{1'b1}} >> (64 - ntc_pkg::LongBits))) :
                                 (raw & ({64{1'b1}} >> (64 - ntc_pkg::LongBits)));
      endcase
   end

   always_comb begin
      neg   = ival[63];
      mag   = neg ? (~ival + 64'd1) : ival;
      lz    = 7'd0;
      found = 1'b0;
      for (int i = 63; i >= 0; i--) begin
         if (!found && mag[i]) begin
            found = 1'b1;
            lz    = 7'(63 - i);
         end
      end
      norm    = mag << lz;
      exp_int = 11'(1023 + 63) - 11'(lz);
      rnd_up  = norm[10] && (norm[9:0] != 10'd0 || norm[11]);
      mant_r  = {1'b0, norm[63:11]} + 54'(rnd_up);
      if (!found) begin
         int_dbl = 64'd0;
      end else if (mant_r[53]) begin
         int_dbl = {neg, exp_int + 11'd1, 52'd0};
      end else begin
         int_dbl = {neg, exp_int, mant_r[51:0]};
      end
   end

   always_comb begin
      f_exp   = raw[30:23];
      f_man   = raw[22:0];
      f_lz    = 5'd0;
      f_found = 1'b0;
      for (int i = 22; i >= 0; i--) begin
         if (!f_found && f_man[i]) begin
            f_found = 1'b1;
            f_lz    = 5'(22 - i);
         end
      end
      f_norm = f_man << (f_lz + 5'd1);
      if (f_exp == 8'hFF) begin
         flt_dbl = {raw[31], 11'h7FF, (f_man != 23'd0), f_man[21:0], 29'd0};
      end else if (f_exp != 8'd0) begin
         flt_dbl = {raw[31], 11'(f_exp) + 11'd896, f_man, 29'd0};
      end else if (!f_found) begin
         flt_dbl = {raw[31], 63'd0};
      end else begin
         flt_dbl = {raw[31], 11'd896 - 11'(f_lz), f_norm, 29'd0};
      end
   end

   always_comb begin
      case (source_type) inside
         ntc_pkg::TYPE_FLOAT32: dbl = flt_dbl;
         ntc_pkg::TYPE_INT8, ntc_pkg::TYPE_INT16,
         ntc_pkg::TYPE_INT32, ntc_pkg::TYPE_LONG: dbl = int_dbl;
         default: dbl = raw;
      endcase
   end

endmodule

// ===== hdl/ntc_encode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_encode
// Turns float64 bits into the configured target type with saturation.
// ----------------------------------------------------------------------------
module ntc_encode (
   input  ntc_pkg::num_type_type target_type,
   input  logic                  round_enable,
   input  logic [63:0]           dbl,
   output logic [63:0]           raw,
   output logic                  saturated
);

   // integer path: fixed point magnitude of x, then y = x + 0.5 rounded in float64
   logic        sgn;
   logic [10:0] ex;
   logic [51:0] fr;
   logic        is_nan;
   logic        is_inf;
   logic [52:0] sig;
   logic        y_neg;
   logic        y_big;
   logic [64:0] tq;
   logic [64:0] sh;
   logic [6:0]  width;
   logic [63:0] hi_val;
   logic [63:0] lo_val;
   logic [64:0] lim;
   logic [63:0] int_res;
   logic        int_sat;
   logic [128:0] wide;

   always_comb begin
      sgn    = dbl[63];
      ex     = dbl[62:52];
      fr     = dbl[51:0];
      is_nan = (ex == 11'h7FF) && (fr != 52'd0);
      is_inf = (ex == 11'h7FF) && (fr == 52'd0);
      sig    = {(ex != 11'd0), fr};
      // value = sig * 2^(ex-1075); express in units of 1/2^64 fixed after shift
      wide = '0;
      if (ex >= 11'd1075) begin
         if (ex > 11'd1075 + 11'd12) begin
            wide = {129{1'b1}};
         end else begin
            wide = 129'(sig) << (7'(ex - 11'd1075) + 7'd64);
         end
      end else if (ex + 11'd64 >= 11'd1075) begin
         wide = (129'(sig) << 64) >> (7'(11'd1075 - ex));
      end else begin
         wide = 129'(ex != 11'd0 || fr != 52'd0);
      end
      // wide: [128:64] integer, [63:0] fraction (sticky at lsb for tiny)
      y_neg    = sgn;
      y_big    = (wide[128:64] > 65'h0_FFFF_FFFF_FFFF_FFFF) || (wide == {129{1'b1}});
      tq       = wide[128:64];
      if (round_enable) begin
         if (!sgn) begin
            if (ex == 11'd1075) begin
               tq = wide[128:64] + 65'(fr[0]);
            end else if (ex == 11'd1021 && fr == {52{1'b1}}) begin
               tq = 65'd1;
            end else begin
               tq = wide[128:64] + 65'(wide[63]);
            end
         end else if (wide[128:63] == 66'd0) begin
            tq    = '0;
            y_neg = 1'b0;
         end else if (wide[63]) begin
            tq = wide[128:64];
         end else if (wide[62:0] != 63'd0 || ex < 11'd1075) begin
            tq = wide[128:64] - 65'd1;
         end else if (ex == 11'd1075) begin
            tq = wide[128:64] - ((fr == 52'd0) ? 65'd1 : 65'(fr[0]));
         end
      end
      sh = tq;
      unique case (target_type)
         ntc_pkg::TYPE_INT8:  width = 7'd8;
         ntc_pkg::TYPE_INT16: width = 7'd16;
         ntc_pkg::TYPE_INT32: width = 7'd32;
         default:             width = 7'(ntc_pkg::LongBits);
      endcase
      hi_val = ({64{1'b1}} >> (7'd65 - width));
      lo_val = ~hi_val;
      lim    = 65'(hi_val) + 65'd1;
      int_sat = 1'b0;
      if (is_nan) begin
         int_res = 64'd0;
         int_sat = 1'b1;
      end else if (!y_neg) begin
         if (is_inf || y_big || sh >= lim) begin
            int_res = hi_val;
            int_sat = 1'b1;
         end else begin
            int_res = sh[63:0];
         end
      end else begin
         if (is_inf || y_big || sh > lim) begin
            int_res = lo_val;
            int_sat = 1'b1;
         end else if (sh >= lim) begin
            int_res = lo_val;
         end else begin
            int_res = ~sh[63:0] + 64'd1;
         end
      end
   end

   // float32 path
   logic [11:0] fe;
   logic [24:0] fm;
   logic [31:0] f32;
   logic        f32_sat;
   logic [77:0] dn;
   logic        g;
   logic        st;
   logic [24:0] mr;
   logic [6:0]  dsh;

   always_comb begin
      f32_sat = 1'b0;
      fe  = 12'(ex) - 12'd896;
      fm  = '0;
      mr  = '0;
      dn  = '0;
      g   = 1'b0;
      st  = 1'b0;
      dsh = '0;
      if (is_nan) begin
         f32 = {sgn, 8'hFF, 1'b1, fr[50:29]};
      end else if (is_inf) begin
         f32 = {sgn, 8'hFF, 23'd0};
      end else if (ex > 11'd1150) begin
         f32 = {sgn, 31'h7F7FFFFF};
         f32_sat = 1'b1;
      end else if (ex >= 11'd897) begin
         g  = fr[28];
         st = fr[27:0] != 28'd0;
         mr = {2'b01, fr[51:29]} + 25'(g && (st || fr[29]));
         if (mr[24]) fe = fe + 12'd1;
         if (fe >= 12'd255) begin
            f32 = {sgn, 31'h7F7FFFFF};
            f32_sat = 1'b1;
         end else begin
            f32 = {sgn, fe[7:0], mr[24] ? mr[23:1] : mr[22:0]};
         end
      end else if (ex + 11'd25 < 11'd897 || ex == 11'd0) begin
         f32 = {sgn, 31'd0};
      end else begin
         dsh = 7'(11'd897 - ex);
         dn  = {1'b1, fr, 25'd0} >> dsh;
         g   = dn[53];
         st  = dn[52:0] != 53'd0;
         fm  = {1'b0, dn[77:54]} + 25'(g && (st || dn[54]));
         f32 = {sgn, 31'(fm)};
      end
   end

   always_comb begin
      case (target_type) inside
         ntc_pkg::TYPE_INT8, ntc_pkg::TYPE_INT16,
         ntc_pkg::TYPE_INT32, ntc_pkg::TYPE_LONG: begin
            raw = int_res;
            saturated = int_sat;
         end
         ntc_pkg::TYPE_FLOAT32: begin
            raw = {32'd0, f32};
            saturated = f32_sat;
         end
         default: begin
            raw = is_nan ? (dbl | 64'h0008_0000_0000_0000) : dbl;
            saturated = 1'b0;
         end
      endcase
   end

endmodule

// ===== hdl/numeric_type_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// numeric_type_converter_unit
// Converts one 64-bit word per cycle unless stalled, int8/16/32/64 and float32/64.
// ----------------------------------------------------------------------------
// Usage: a request (req_raw_in) is taken when req_valid is high and req_stall
// low. It is registered, decoded to float64, encoded to the target type and
// held in a result register. The response (rsp_raw_out, rsp_saturated) shows
// with rsp_valid and is taken when rsp_stall is low.
// Path: input register, then result register. Throughput: one request per
// cycle while the result register is not stalled; decode and encode sit between.
// Stall: while rsp_stall holds a full result register, req_stall rises once
// the input register is full as well; nothing is dropped.
// Configuration: csr_valid/csr_ready with csr_index and csr_data; ready is
// always high. Write only while idle.
// Reset: both stages empty; source and target float32, rounding off.
// ----------------------------------------------------------------------------
module numeric_type_converter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_raw_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_raw_out,
   output logic        rsp_saturated,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_data
);

   ntc_pkg::cfg_type cfg_ff, cfg_in;
   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] s1_raw_ff, s1_raw_in;
   logic        s2_valid_ff, s2_valid_in;
   logic [63:0] s2_raw_ff, s2_raw_in;
   logic        s2_sat_ff, s2_sat_in;
   logic [63:0] dbl;
   logic [63:0] enc_raw;
   logic        enc_sat;
   logic        s2_load;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (ntc_pkg::csr_index_type'(csr_index))
            ntc_pkg::CSR_SOURCE_TYPE:
               cfg_in.source_type = ntc_pkg::num_type_type'(csr_data[2:0]);
            ntc_pkg::CSR_TARGET_TYPE:
               cfg_in.target_type = ntc_pkg::num_type_type'(csr_data[2:0]);
            ntc_pkg::CSR_ROUND_ENABLE: cfg_in.round_enable = csr_data[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   ntc_decode u_decode (
      .source_type(cfg_ff.source_type),
      .raw        (s1_raw_ff),
      .dbl        (dbl)
   );

   ntc_encode u_encode (
      .target_type (cfg_ff.target_type),
      .round_enable(cfg_ff.round_enable),
      .dbl         (dbl),
      .raw         (enc_raw),
      .saturated   (enc_sat)
   );

   assign s2_load   = !s2_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s2_load;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_raw_in   = s1_raw_ff;
      s2_valid_in = s2_valid_ff;
      s2_raw_in   = s2_raw_ff;
      s2_sat_in   = s2_sat_ff;
      if (s2_load) begin
         s2_valid_in = s1_valid_ff;
         s2_raw_in   = enc_raw;
         s2_sat_in   = enc_sat;
      end
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_raw_in   = req_raw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '{ntc_pkg::TYPE_FLOAT32, ntc_pkg::TYPE_FLOAT32, 1'b0};
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_raw_ff <= s1_raw_in;
      s2_raw_ff <= s2_raw_in;
      s2_sat_ff <= s2_sat_in;
   end

   assign rsp_valid     = s2_valid_ff;
   assign rsp_raw_out   = s2_raw_ff;
   assign rsp_saturated = s2_sat_ff;

endmodule

// ===== hdl/ntc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntc_checker
// Port level checks of the numeric type converter.
// ----------------------------------------------------------------------------
module ntc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_raw_out,
   input logic        csr_ready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_raw_out))
      else $error("stalled response changed");

   a_no_stall_when_drain: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("response missing after two cycles");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

endmodule

bind numeric_type_converter_unit ntc_checker u_ntc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_stall  (req_stall),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_raw_out(rsp_raw_out),
   .csr_ready  (csr_ready)
);

// ===== tb/tb_numeric_type_converter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_numeric_type_converter_unit
// Checks the numeric type converter against its own bit-exact conversion
// predictor. The test steps through every source/target type pair, the
// reserved codes, and both rounding settings. Requests are a short directed
// list followed by random words aimed at range edges, rounding ties, NaN and
// infinity. Both sides idle at random, and once the receiver holds off for a
// long time to back up the pipe.
// ----------------------------------------------------------------------------
module tb_numeric_type_converter_unit;

   typedef struct {
      logic [63:0] raw;
      logic        sat;
   } conv_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_raw_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_raw_out;
   logic        rsp_saturated;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   ntc_pkg::csr_index_type csr_index = ntc_pkg::CSR_NONE;
   logic [63:0] csr_data = '0;

   logic [63:0]           pending_words[$];
   conv_result_type       expected_results[$];
   logic [63:0]           special_words[$];
   ntc_pkg::num_type_type cur_source = ntc_pkg::TYPE_FLOAT32;
   ntc_pkg::num_type_type cur_target = ntc_pkg::TYPE_FLOAT32;
   logic                  cur_round = 1'b0;
   int                    errors = 0;
   int                    sent_count = 0;
   int                    req_gap = 0;
   int                    rsp_gap = 0;
   int                    hold_left = 0;
   bit                    hold_done = 1'b0;
   bit                    quiet = 1'b0;
   int                    idle_cycles = 0;

   numeric_type_converter_unit dut (.*);

   always #4 clock = ~clock;

   function automatic real pow2(int n);
      real p;
      p = 1.0;
      for (int i = 0; i < n; i++) p = p * 2.0;
      return p;
   endfunction

   function automatic bit is_nan64(logic [63:0] b);
      return b[62:52] == 11'h7FF && b[51:0] != 0;
   endfunction

   function automatic logic [63:0] widen_single(logic [31:0] u);
      logic [63:0] b;
      int p;
      b = {u[31], 63'b0};
      if (u[30:23] == 8'hFF) begin
         if (u[22:0] != 0) b = {u[31], 11'h7FF, 1'b1, u[21:0], 29'b0};
         else b = {u[31], 11'h7FF, 52'b0};
      end else if (u[30:23] == 0) begin
         if (u[22:0] != 0) begin
            p = 0;
            for (int i = 0; i < 23; i++) if (u[i]) p = i;
            b[62:52] = 11'(p - 149 + 1023);
            b[51:0] = 52'({29'b0, u[22:0]} << (52 - p));
         end
      end else begin
         b = {u[31], 11'(u[30:23] - 127 + 1023), u[22:0], 29'b0};
      end
      return b;
   endfunction

   function automatic longint trunc_real(real y);
      logic [63:0] yb, m, mag;
      int e;
      yb = $realtobits(y);
      e = yb[62:52];
      m = {11'b0, 1'b1, yb[51:0]};
      if (e < 1023) mag = 0;
      else if (e >= 1075) mag = m << (e - 1075);
      else mag = m >> (1075 - e);
      return yb[63] ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic conv_result_type narrow_int(real x, logic [63:0] xb, int w);
      conv_result_type r;
      longint hi, lo;
      real hid, lod, y;
      hi = longint'((64'h1 << (w - 1)) - 64'h1);
      lo = -hi - 1;
      hid = pow2(w - 1);
      lod = -hid;
      y = cur_round ? x + 0.5 : x;
      r.sat = 1'b0;
      if (is_nan64(xb)) begin
         r.raw = '0;
         r.sat = 1'b1;
      end else if (y >= hid) begin
         r.raw = hi;
         r.sat = 1'b1;
      end else if (y < lod) begin
         r.raw = lo;
         r.sat = !(y > lod - 1.0);
      end else begin
         r.raw = trunc_real(y);
      end
      return r;
   endfunction

   function automatic conv_result_type narrow_single(real x, logic [63:0] xb);
      conv_result_type r;
      real fmax, thr, ax;
      logic [63:0] m, q, rem, half;
      int e, sh;
      fmax = real'(64'd16777215) * pow2(104);
      thr = real'(64'd33554431) * pow2(103);
      r.sat = 1'b0;
      r.raw = {32'b0, xb[63], 31'b0};
      if (is_nan64(xb)) begin
         r.raw[30:0] = {9'h1FF, xb[50:29]};
         return r;
      end
      ax = x < 0.0 ? -x : x;
      if (ax > fmax) begin
         if (xb[62:0] == 63'h7FF0000000000000) r.raw[30:0] = 31'h7F800000;
         else begin
            r.raw[30:0] = 31'h7F7FFFFF;
            r.sat = ax >= thr;
         end
         return r;
      end
      e = int'(xb[62:52]) - 1023;
      if (xb[62:52] == 0) return r;
      m = {11'b0, 1'b1, xb[51:0]};
      sh = e >= -126 ? 29 : 29 + (-126 - e);
      if (sh > 60) return r;
      q = m >> sh;
      rem = m & ((64'h1 << sh) - 1);
      half = 64'h1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      if (e >= -126) begin
         if (q[24]) begin
            q = q >> 1;
            e = e + 1;
         end
         r.raw[30:0] = {8'(e + 127), q[22:0]};
      end else begin
         r.raw[30:0] = q[30:0];
      end
      return r;
   endfunction

   function automatic conv_result_type convert_word(logic [63:0] v);
      conv_result_type r;
      logic [63:0] xb;
      real x;
      case (cur_source)
         ntc_pkg::TYPE_INT8:    xb = $realtobits(real'(longint'($signed(v[7:0]))));
         ntc_pkg::TYPE_INT16:   xb = $realtobits(real'(longint'($signed(v[15:0]))));
         ntc_pkg::TYPE_INT32:   xb = $realtobits(real'(longint'($signed(v[31:0]))));
         ntc_pkg::TYPE_LONG:    xb = $realtobits(real'($signed(v)));
         ntc_pkg::TYPE_FLOAT32: xb = widen_single(v[31:0]);
         default:               xb = v;
      endcase
      x = $bitstoreal(xb);
      case (cur_target)
         ntc_pkg::TYPE_INT8:    r = narrow_int(x, xb, 8);
         ntc_pkg::TYPE_INT16:   r = narrow_int(x, xb, 16);
         ntc_pkg::TYPE_INT32:   r = narrow_int(x, xb, 32);
         ntc_pkg::TYPE_LONG:    r = narrow_int(x, xb, ntc_pkg::LongBits);
         ntc_pkg::TYPE_FLOAT32: r = narrow_single(x, xb);
         default: begin
            r.raw = is_nan64(xb) ? xb | 64'h0008000000000000 : xb;
            r.sat = 1'b0;
         end
      endcase
      return r;
   endfunction

   function automatic logic [63:0] random_word();
      logic [63:0] w;
      w = {$urandom, $urandom};
      case ($urandom_range(0, 6))
         0: w = special_words[$urandom_range(0, special_words.size() - 1)];
         1: w = 64'($signed(32'($urandom_range(0, 600)) - 32'sd300));
         2: w = {w[63], 11'(1023 + $urandom_range(0, 70)), w[51:0]};
         3: w = $realtobits(real'(int'($urandom_range(0, 400)) - 200) + 0.5);
         4: w = {w[63:32], w[31], 8'($urandom_range(0, 3) == 0 ? 0 : 255), w[22:0]};
         5: w = {w[63], 11'($urandom_range(0, 1) ? 1023 + 120 + $urandom_range(0, 16)
                                            : 1023 - 160 + $urandom_range(0, 40)),
                 w[51:0]};
         default: ;
      endcase
      return w;
   endfunction

   task automatic report(string what, logic [63:0] want, logic [63:0] got);
      $display("mismatch %s: expected %h got %h", what, want, got);
      errors++;
   endtask

   task automatic write_csr(ntc_pkg::csr_index_type idx, logic [63:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ntc_pkg::CSR_SOURCE_TYPE:  cur_source = ntc_pkg::num_type_type'(data[2:0]);
         ntc_pkg::CSR_TARGET_TYPE:  cur_target = ntc_pkg::num_type_type'(data[2:0]);
         ntc_pkg::CSR_ROUND_ENABLE: cur_round = data[0];
         default: ;
      endcase
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_words.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic run_phase(ntc_pkg::num_type_type src, ntc_pkg::num_type_type dst,
                            logic rnd, int count);
      write_csr(ntc_pkg::CSR_SOURCE_TYPE, 64'(src));
      write_csr(ntc_pkg::CSR_TARGET_TYPE, 64'(dst));
      write_csr(ntc_pkg::CSR_ROUND_ENABLE, 64'(rnd));
      for (int i = 0; i < count; i++) pending_words.push_back(random_word());
      drain();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(convert_word(req_raw_in));
            sent_count <= sent_count + 1;
            if ($urandom_range(0, 40) == 0) quiet <= ~quiet;
         end
         if (!req_valid || !req_stall) begin
            if (req_gap != 0) begin
               req_gap <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_valid <= 1'b1;
               req_raw_in <= pending_words.pop_front();
               req_gap <= quiet ? 0 : $urandom_range(0, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      conv_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report("unexpected response", '0, rsp_raw_out);
            end else begin
               want = expected_results.pop_front();
               if (rsp_raw_out !== want.raw) report("raw_out", want.raw, rsp_raw_out);
               if (rsp_saturated !== want.sat)
                  report("saturated", 64'(want.sat), 64'(rsp_saturated));
            end
            rsp_gap <= quiet ? 0 : $urandom_range(0, 4);
         end
         if (!hold_done && sent_count >= 300) begin
            hold_done <= 1'b1;
            hold_left <= 150;
            rsp_stall <= 1'b1;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_gap != 0 && !(rsp_valid && !rsp_stall)) begin
            rsp_gap <= rsp_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
         $display("timeout");
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      special_words = '{64'h0, 64'hFFFFFFFFFFFFFFFF, 64'h7F, 64'h80, 64'h7FFF, 64'h8000,
                        64'h7FFFFFFF, 64'h80000000, 64'h7FFFFFFFFFFFFFFF,
                        64'h8000000000000000, 64'h7FC00001, 64'hFF800001, 64'h7F800000,
                        64'hFF800000, 64'h1, 64'h7F7FFFFF, 64'h7FF0000000000001,
                        64'hFFF0000000000000, 64'h7E37E43C8800759C, 64'h400C000000000000,
                        64'hC004000000000000, 64'hBFE0000000000000, 64'h36A0000000000000,
                        64'h47EFFFFFF0000000, 64'hC3E0000000000000};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_csr(ntc_pkg::CSR_SOURCE_TYPE, 64'(ntc_pkg::TYPE_FLOAT64));
      write_csr(ntc_pkg::CSR_TARGET_TYPE, 64'(ntc_pkg::TYPE_INT32));
      write_csr(ntc_pkg::CSR_ROUND_ENABLE, 64'd1);
      foreach (special_words[i]) pending_words.push_back(special_words[i]);
      drain();
      for (int s = 0; s < 6; s++)
         for (int t = 0; t < 6; t++)
            run_phase(ntc_pkg::num_type_type'(s), ntc_pkg::num_type_type'(t),
                      1'($urandom_range(0, 1)), 15);
      run_phase(ntc_pkg::TYPE_RSVD6, ntc_pkg::TYPE_RSVD7, 1'b1, 10);
      run_phase(ntc_pkg::TYPE_RSVD7, ntc_pkg::TYPE_INT8, 1'b0, 10);
      run_phase(ntc_pkg::TYPE_FLOAT32, ntc_pkg::TYPE_RSVD6, 1'b1, 10);
      run_phase(ntc_pkg::TYPE_LONG, ntc_pkg::TYPE_LONG, 1'b1, 10);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/ntc_pkg.sv
hdl/ntc_decode.sv
hdl/ntc_encode.sv
hdl/numeric_type_converter_unit.sv
hdl/ntc_checker.sv
tb/tb_numeric_type_converter_unit.sv
